[hdl/ttfl_pkg.sv]
// ----------------------------------------------------------------------------
// ttfl_pkg
// Shared types and constants for the timer table with free list.
// ----------------------------------------------------------------------------
package ttfl_pkg;

    localparam int IDX_W  = 6;
    localparam int SLOT_W = 8;
    localparam int TIME_W = 32;
    localparam int HND_W  = 8;
    localparam int ARG_W  = 32;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_SCAN = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_INVALID  = 3'd3,
        ST_INACTIVE = 3'd4,
        ST_EXPIRED  = 3'd5,
        ST_DONE     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_EMIT,
        S_DEL_EMIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_DONE
    } state_t;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] scan_idx;
        logic             add_commit;
        logic             release_id;
        logic             release_scan;
        logic             emit;
        status_t          emit_status;
    } ttfl_cmd_t;

    typedef struct packed {
        logic head_full;
        logic id_invalid;
        logic id_active;
        logic scan_hit;
        logic out_free;
    } ttfl_stat_t;

endpackage

[hdl/timer_table_free_list.sv]
// ----------------------------------------------------------------------------
// timer_table_free_list
// Timer slot table with a LIFO free list: add, delete and expiry scan.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_       | in        | opcode, now_time, timeout, handler, arg, timer_id
//  m_       | out       | status, slot, handler_out, arg_out, last
//
//  add and delete: one table access plus the result register
//  scan: one slot per cycle through the read port unless a hit is stalled
//  one word is worked on at a time; a stalled result holds the sequencer
//  reset is synchronous; the free list starts as 0..NUM_TIMERS-1 with no sweep
// ----------------------------------------------------------------------------
module timer_table_free_list
    import ttfl_pkg::*;
#(
    parameter int NUM_TIMERS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [TIME_W-1:0] s_now_time,
    input  logic [TIME_W-1:0] s_timeout,
    input  logic [HND_W-1:0]  s_handler,
    input  logic [ARG_W-1:0]  s_arg,
    input  logic [SLOT_W-1:0] s_timer_id,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [HND_W-1:0]  m_handler_out,
    output logic [ARG_W-1:0]  m_arg_out,
    output logic              m_last
);

    ttfl_cmd_t  cmd;
    ttfl_stat_t stat;

    ttfl_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttfl_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_now_time    (s_now_time),
        .s_timeout     (s_timeout),
        .s_handler     (s_handler),
        .s_arg         (s_arg),
        .s_timer_id    (s_timer_id),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_handler_out (m_handler_out),
        .m_arg_out     (m_arg_out),
        .m_last        (m_last)
    );

endmodule

[hdl/ttfl_ctrl.sv]
// ----------------------------------------------------------------------------
// ttfl_ctrl
// Sequencer for add, delete and scan; drives the datapath by command word.
// ----------------------------------------------------------------------------
module ttfl_ctrl
    import ttfl_pkg::*;
#(
    parameter int NUM_TIMERS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_opcode,
    output logic       s_ready,
    input  ttfl_stat_t stat,
    output ttfl_cmd_t  cmd
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_ready      = 1'b0;
        advance      = 1'b0;
        cmd          = '0;
        cmd.scan_idx = idx_reg;
        cmd.rd_addr  = idx_reg;
        cmd.emit_status = ST_ADDED;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                idx_next = '0;
                if (s_valid) begin
                    unique case (opcode_t'(s_opcode))
                        OP_ADD:  state_next = S_ADD_EMIT;
                        OP_DEL:  state_next = S_DEL_EMIT;
                        OP_SCAN: state_next = S_SCAN_RD;
                        OP_NONE: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = stat.head_full ? ST_FULL : ST_ADDED;
                    cmd.add_commit  = !stat.head_full;
                    state_next      = S_IDLE;
                end
            end
            S_DEL_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    priority if (stat.id_invalid) begin
                        cmd.emit_status = ST_INVALID;
                    end else if (!stat.id_active) begin
                        cmd.emit_status = ST_INACTIVE;
                    end else begin
                        cmd.emit_status = ST_DELETED;
                        cmd.release_id  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (stat.scan_hit) begin
                    if (stat.out_free) begin
                        cmd.emit         = 1'b1;
                        cmd.emit_status  = ST_EXPIRED;
                        cmd.release_scan = 1'b1;
                        advance          = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
                if (advance) begin
                    cmd.rd_addr = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_SCAN_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SCAN_DONE: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DONE;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // scan index never runs past the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("scan index out of range");

    // a scan always ends with one done word before idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_DONE && state_next == S_IDLE) |-> cmd.emit)
        else $error("scan left without done word");

    // input is taken only in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("load outside idle");

endmodule

[hdl/ttfl_dp.sv]
// ----------------------------------------------------------------------------
// ttfl_dp
// Slot storage, free list, active bits and result register.
// ----------------------------------------------------------------------------
module ttfl_dp
    import ttfl_pkg::*;
#(
    parameter int NUM_TIMERS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [TIME_W-1:0] s_now_time,
    input  logic [TIME_W-1:0] s_timeout,
    input  logic [HND_W-1:0]  s_handler,
    input  logic [ARG_W-1:0]  s_arg,
    input  logic [SLOT_W-1:0] s_timer_id,
    input  ttfl_cmd_t         cmd,
    output ttfl_stat_t        stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [HND_W-1:0]  m_handler_out,
    output logic [ARG_W-1:0]  m_arg_out,
    output logic              m_last
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int HW = $clog2(NUM_TIMERS + 1);

    // storage
    logic [TIME_W-1:0] expiry_mem  [NUM_TIMERS];
    logic [HND_W-1:0]  handler_mem [NUM_TIMERS];
    logic [ARG_W-1:0]  arg_mem     [NUM_TIMERS];
    logic [HW-1:0]     nfree_mem   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] nf_wr_reg;
    logic [HW-1:0]     head_reg;

    // latched input word
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] exp_in_reg;
    logic [HND_W-1:0]  hnd_reg;
    logic [ARG_W-1:0]  arg_reg;
    logic [SLOT_W-1:0] id_reg;

    // registered reads
    logic [TIME_W-1:0] exp_rd_reg;
    logic [HND_W-1:0]  hnd_rd_reg;
    logic [ARG_W-1:0]  arg_rd_reg;
    logic [HW-1:0]     nf_rd_reg;
    logic              nf_wr_rd_reg;
    logic [HW-1:0]     head_inc_reg;

    // result register
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [HND_W-1:0]  m_hnd_reg;
    logic [ARG_W-1:0]  m_arg_reg;

    logic [SW-1:0]     head_idx;
    logic [SW-1:0]     id_idx;
    logic [SW-1:0]     scan_idx;
    logic [SW-1:0]     rd_idx;
    logic [SW-1:0]     rel_idx;
    logic              rel_en;
    logic [HW-1:0]     head_pop;
    logic [SLOT_W-1:0] slot_val;

    assign head_idx = head_reg[SW-1:0];
    assign id_idx   = id_reg[SW-1:0];
    assign scan_idx = cmd.scan_idx[SW-1:0];
    assign rd_idx   = cmd.rd_addr[SW-1:0];
    assign rel_en   = cmd.release_id | cmd.release_scan;
    assign rel_idx  = cmd.release_scan ? scan_idx : id_idx;
    assign head_pop = nf_wr_rd_reg ? nf_rd_reg : head_inc_reg;

    assign stat.head_full  = (head_reg >= HW'(NUM_TIMERS));
    assign stat.id_invalid = (id_reg >= SLOT_W'(NUM_TIMERS));
    assign stat.id_active  = active_reg[id_idx];
    assign stat.scan_hit   = active_reg[scan_idx] && (exp_rd_reg <= now_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg    <= s_now_time;
            exp_in_reg <= s_now_time + s_timeout;
            hnd_reg    <= s_handler;
            arg_reg    <= s_arg;
            id_reg     <= s_timer_id;
        end
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (cmd.add_commit) begin
            expiry_mem[head_idx]  <= exp_in_reg;
            handler_mem[head_idx] <= hnd_reg;
            arg_mem[head_idx]     <= arg_reg;
        end
        exp_rd_reg <= expiry_mem[rd_idx];
        hnd_rd_reg <= handler_mem[rd_idx];
        arg_rd_reg <= arg_mem[rd_idx];
    end

    // free list links
    always_ff @(posedge aclk) begin
        if (rel_en) begin
            nfree_mem[rel_idx] <= head_reg;
        end
        nf_rd_reg    <= nfree_mem[head_idx];
        nf_wr_rd_reg <= nf_wr_reg[head_idx];
        head_inc_reg <= head_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            nf_wr_reg  <= '0;
            head_reg   <= '0;
        end else begin
            if (cmd.add_commit) begin
                active_reg[head_idx] <= 1'b1;
                head_reg             <= head_pop;
            end
            if (rel_en) begin
                active_reg[rel_idx] <= 1'b0;
                nf_wr_reg[rel_idx]  <= 1'b1;
                head_reg            <= HW'(rel_idx);
            end
        end
    end

    always_comb begin
        unique case (cmd.emit_status)
            ST_ADDED:    slot_val = SLOT_W'(head_idx);
            ST_DELETED,
            ST_INVALID,
            ST_INACTIVE: slot_val = id_reg;
            ST_EXPIRED:  slot_val = SLOT_W'(scan_idx);
            default:     slot_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_slot_reg   <= slot_val;
            m_hnd_reg    <= (cmd.emit_status == ST_EXPIRED) ? hnd_rd_reg : '0;
            m_arg_reg    <= (cmd.emit_status == ST_EXPIRED) ? arg_rd_reg : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_handler_out = m_hnd_reg;
    assign m_arg_out     = m_arg_reg;
    assign m_last        = (m_status_reg != ST_EXPIRED);

    // free list head never points beyond one past the table (the full mark)
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= HW'(NUM_TIMERS))
        else $error("free list head out of range");

    // an allocated slot must have been free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_commit |-> !active_reg[head_idx])
        else $error("allocated slot already active");

    // only an active slot goes back on the free list
    assert property (@(posedge aclk) disable iff (!aresetn)
        rel_en |-> active_reg[rel_idx])
        else $error("released slot not active");

    // a result is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten");

endmodule
